>>> design/ptq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types and codes of the proximity tag qualifier.
// ----------------------------------------------------------------------------
package ptq_pkg;

  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_ADDED   = 3'd1,
    ST_UPDATED = 3'd2,
    ST_FULL    = 3'd3,
    ST_POLLED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_NEEDED    = 2'd1,
    REG_WINDOW    = 2'd2
  } reg_index_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_CHECK,
    FSM_WRITE,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic        cmd;
    logic        has_key;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic signed [7:0] strength;
    logic [31:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [63:0] found_high;
    logic [63:0] found_low;
    logic [4:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [7:0]  count;
    logic [31:0] first_time;
  } entry_t;

  localparam int unsigned CfgWidth = 32;

endpackage

>>> design/proximity_tag_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_tag_qualifier
// Ordered tag table in one synchronous memory, walked one entry at a time.
// ----------------------------------------------------------------------------
// Sequence: a walk visits each used entry in a read state and a check state (compare or
// compaction), then does a final read, a write and a done state that registers the
// result; a sighting that matches an entry goes from its check state to done, and a
// weak or keyless sighting goes straight to done. One transaction is in flight: the next
// is accepted once the result is registered and the block is idle again.
// Reset clears the entry count and control state and loads the configuration defaults;
// data registers and memory contents stay undefined, and no entry is used before written.
module proximity_tag_qualifier
  import ptq_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgWidth-1:0] cfg_data_i
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic signed [7:0] thr_q;
  logic [7:0]  need_q;
  logic [31:0] win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= -8'sd60;
      need_q <= 8'd2;
      win_q  <= 32'd6000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_THRESHOLD: thr_q  <= cfg_data_i[7:0];
        REG_NEEDED:    need_q <= cfg_data_i[7:0];
        REG_WINDOW:    win_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  fsm_e state_q, state_d;
  in_item_t  item_q, item_d;
  out_item_t res_q, res_d;
  out_item_t out_data_q, out_data_d;
  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] used_q, used_d, idx_q, idx_d, wr_q, wr_d;
  logic          hit_q, hit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      used_q      <= '0;
      idx_q       <= '0;
      wr_q        <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      wr_q        <= wr_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  logic [31:0] age;
  logic        key_eq;
  assign age    = item_q.time_now - rd_q.first_time;
  assign key_eq = (rd_q.key_high == item_q.key_high) && (rd_q.key_low == item_q.key_low);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    used_d      = used_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    waddr       = wr_q[AW-1:0];
    wdata       = rd_q;
    raddr       = idx_q[AW-1:0];
    in_stall_o  = 1'b1;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d = in_data_i;
          res_d  = '0;
          idx_d  = '0;
          wr_d   = '0;
          hit_d  = 1'b0;
          if (!in_data_i.cmd &&
              ((in_data_i.strength < thr_q) || !in_data_i.has_key)) begin
            res_d.status = ST_IGNORED;
            state_d      = FSM_DONE;
          end else begin
            state_d = FSM_READ;
          end
        end
      end
      FSM_READ: begin
        // Address idx_q is presented; data arrives next cycle.
        if (idx_q == used_q) state_d = FSM_WRITE;
        else state_d = FSM_CHECK;
      end
      FSM_CHECK: begin
        state_d = FSM_READ;
        idx_d   = idx_q + 1'b1;
        if (!item_q.cmd) begin
          if (key_eq) begin
            hit_d        = 1'b1;
            we           = 1'b1;
            waddr        = idx_q[AW-1:0];
            if (rd_q.count != 8'hFF) wdata.count = rd_q.count + 8'd1;
            res_d.status = ST_UPDATED;
            state_d      = FSM_DONE;
          end
        end else if (age > win_q) begin
          // Expired entry is dropped.
        end else if (rd_q.count >= need_q) begin
          res_d.found      = 1'b1;
          res_d.found_high = rd_q.key_high;
          res_d.found_low  = rd_q.key_low;
        end else begin
          we    = 1'b1;
          waddr = wr_q[AW-1:0];
          wr_d  = wr_q + 1'b1;
        end
      end
      FSM_WRITE: begin
        state_d = FSM_DONE;
        if (item_q.cmd) begin
          used_d       = wr_q;
          res_d.status = ST_POLLED;
        end else if (used_q < CW'(TABLE_DEPTH)) begin
          we               = 1'b1;
          waddr            = used_q[AW-1:0];
          wdata.key_high   = item_q.key_high;
          wdata.key_low    = item_q.key_low;
          wdata.count      = 8'd1;
          wdata.first_time = item_q.time_now;
          used_d           = used_q + 1'b1;
          res_d.status     = ST_ADDED;
        end else begin
          res_d.status = ST_FULL;
        end
      end
      FSM_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_data_d           = res_q;
          out_data_d.occupancy = 5'(used_q);
          out_valid_d          = 1'b1;
          state_d              = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(TABLE_DEPTH)) else $error("entry count beyond depth");
  a_wr_le_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= idx_q) else $error("compaction pointer ahead of scan");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_data_q))
    else $error("stalled result changed");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != FSM_IDLE |-> in_stall_o) else $error("input taken while busy");

endmodule
